### hdl/qvr_pkg.sv
package qvr_pkg;

  localparam int OUT_W = 18;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } lane_res_t;

endpackage

### hdl/quaternion_vector_rotate_core.sv
// done is registered, in step with the data from the quaternion products to the merge
// throughput: one transaction per cycle, set by the fully pipelined multipliers
// busy is held low; the receiver cannot stall and results are never held
// rst (synchronous, active high) clears the valid pipeline; data stages are not reset
module quaternion_vector_rotate_core #(
  parameter int VEC_WIDTH = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic signed [QUAT_FRAC_BITS+1:0]    q_w,
  input  logic signed [QUAT_FRAC_BITS+1:0]    q_x,
  input  logic signed [QUAT_FRAC_BITS+1:0]    q_y,
  input  logic signed [QUAT_FRAC_BITS+1:0]    q_z,
  input  logic signed [VEC_WIDTH-1:0]         vec_x,
  input  logic signed [VEC_WIDTH-1:0]         vec_y,
  input  logic signed [VEC_WIDTH-1:0]         vec_z,
  output logic                                done,
  output logic signed [qvr_pkg::OUT_W-1:0]    out_x,
  output logic signed [qvr_pkg::OUT_W-1:0]    out_y,
  output logic signed [qvr_pkg::OUT_W-1:0]    out_z,
  output logic                                saturated
);
  import qvr_pkg::*;

  localparam int EW = QUAT_FRAC_BITS + 7;
  localparam int DEPTH = 5;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] valid_next;
  logic signed [VEC_WIDTH-1:0] vec_in [3];
  logic signed [VEC_WIDTH-1:0] vec_s2 [3];
  logic signed [EW-1:0]        row [3][3];
  lane_res_t                   lane [3];

  assign busy = 1'b0;
  assign done = valid[DEPTH-1];

  assign vec_in[0] = vec_x;
  assign vec_in[1] = vec_y;
  assign vec_in[2] = vec_z;

  assign valid_next = {valid[DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  qvr_matrix #(
    .VEC_WIDTH(VEC_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_matrix (
    .clk(clk),
    .action(action),
    .q_w(q_w),
    .q_x(q_x),
    .q_y(q_y),
    .q_z(q_z),
    .vec_in(vec_in),
    .row(row),
    .vec_out(vec_s2)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    qvr_lane #(
      .VEC_WIDTH(VEC_WIDTH),
      .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_lane (
      .clk(clk),
      .entry(row[i]),
      .vec(vec_s2),
      .res(lane[i])
    );
  end

  qvr_merge u_merge (
    .clk(clk),
    .lane(lane),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .saturated(saturated)
  );

endmodule

### hdl/qvr_matrix.sv
module qvr_matrix #(
  parameter int VEC_WIDTH = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                                         clk,
  input  logic                                         action,
  input  logic signed [QUAT_FRAC_BITS+1:0]             q_w,
  input  logic signed [QUAT_FRAC_BITS+1:0]             q_x,
  input  logic signed [QUAT_FRAC_BITS+1:0]             q_y,
  input  logic signed [QUAT_FRAC_BITS+1:0]             q_z,
  input  logic signed [VEC_WIDTH-1:0]                  vec_in [3],
  output logic signed [QUAT_FRAC_BITS+6:0]             row [3][3],
  output logic signed [VEC_WIDTH-1:0]                  vec_out [3]
);
  import qvr_pkg::*;

  localparam int F  = QUAT_FRAC_BITS;
  localparam int QW = F + 2;
  localparam int PW = 2 * QW;
  localparam int RW = F + 4;
  localparam int EW = F + 7;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);
  localparam logic signed [EW-1:0] ONE  = EW'(1) <<< F;

  logic signed [RW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic                 action_d;
  logic signed [VEC_WIDTH-1:0] vec_d [3];
  logic signed [EW-1:0] r [3][3];

  function automatic logic signed [RW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b)) + HALF;
    return p[PW-1:F];
  endfunction

  // rounded quaternion products
  always_ff @(posedge clk) begin
    xx <= qmul(q_x, q_x);
    yy <= qmul(q_y, q_y);
    zz <= qmul(q_z, q_z);
    xy <= qmul(q_x, q_y);
    xz <= qmul(q_x, q_z);
    yz <= qmul(q_y, q_z);
    wx <= qmul(q_w, q_x);
    wy <= qmul(q_w, q_y);
    wz <= qmul(q_w, q_z);
    action_d <= action;
    vec_d <= vec_in;
  end

  always_comb begin
    r[0][0] = ONE - ((EW'(yy) + EW'(zz)) <<< 1);
    r[0][1] = (EW'(xy) - EW'(wz)) <<< 1;
    r[0][2] = (EW'(xz) + EW'(wy)) <<< 1;
    r[1][0] = (EW'(xy) + EW'(wz)) <<< 1;
    r[1][1] = ONE - ((EW'(xx) + EW'(zz)) <<< 1);
    r[1][2] = (EW'(yz) - EW'(wx)) <<< 1;
    r[2][0] = (EW'(xz) - EW'(wy)) <<< 1;
    r[2][1] = (EW'(yz) + EW'(wx)) <<< 1;
    r[2][2] = ONE - ((EW'(xx) + EW'(yy)) <<< 1);
  end

  // transpose for earth to body
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        row[i][j] <= action_d ? r[j][i] : r[i][j];
      end
    end
    vec_out <= vec_d;
  end

endmodule

### hdl/qvr_lane.sv
module qvr_lane #(
  parameter int VEC_WIDTH = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic signed [QUAT_FRAC_BITS+6:0] entry [3],
  input  logic signed [VEC_WIDTH-1:0]      vec [3],
  output qvr_pkg::lane_res_t               res
);
  import qvr_pkg::*;

  localparam int F  = QUAT_FRAC_BITS;
  localparam int EW = F + 7;
  localparam int MW = EW + VEC_WIDTH;
  localparam int SW = MW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0] MAXV = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] MINV = SW'(OUT_MIN);

  logic signed [MW-1:0] prod [3];
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] rnd;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      prod[j] <= MW'(entry[j]) * MW'(vec[j]);
    end
  end

  always_comb begin
    sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + HALF;
    rnd = sum >>> F;
  end

  // round and clip
  always_ff @(posedge clk) begin
    if (rnd > MAXV) begin
      res.value <= OUT_MAX;
      res.sat   <= 1'b1;
    end else if (rnd < MINV) begin
      res.value <= OUT_MIN;
      res.sat   <= 1'b1;
    end else begin
      res.value <= rnd[OUT_W-1:0];
      res.sat   <= 1'b0;
    end
  end

endmodule

### hdl/qvr_merge.sv
module qvr_merge (
  input  logic                          clk,
  input  qvr_pkg::lane_res_t            lane [3],
  output logic signed [qvr_pkg::OUT_W-1:0] out_x,
  output logic signed [qvr_pkg::OUT_W-1:0] out_y,
  output logic signed [qvr_pkg::OUT_W-1:0] out_z,
  output logic                          saturated
);
  import qvr_pkg::*;

  always_ff @(posedge clk) begin
    out_x     <= lane[0].value;
    out_y     <= lane[1].value;
    out_z     <= lane[2].value;
    saturated <= lane[0].sat | lane[1].sat | lane[2].sat;
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int VEC_W = 16;
  localparam int FRAC = 14;
  localparam int Q_W = FRAC + 2;
  localparam int N_RANDOM = 1230;
  localparam int MAX_GAP = 11;
  localparam int SETTLE_CYCLES = 20;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                    action;
    logic signed [Q_W-1:0]   q_w;
    logic signed [Q_W-1:0]   q_x;
    logic signed [Q_W-1:0]   q_y;
    logic signed [Q_W-1:0]   q_z;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } rot_req_t;

  typedef struct packed {
    logic signed [qvr_pkg::OUT_W-1:0] out_x;
    logic signed [qvr_pkg::OUT_W-1:0] out_y;
    logic signed [qvr_pkg::OUT_W-1:0] out_z;
    logic                             saturated;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = 1'b0;
  logic signed [Q_W-1:0] q_w = '0;
  logic signed [Q_W-1:0] q_x = '0;
  logic signed [Q_W-1:0] q_y = '0;
  logic signed [Q_W-1:0] q_z = '0;
  logic signed [VEC_W-1:0] vec_x = '0;
  logic signed [VEC_W-1:0] vec_y = '0;
  logic signed [VEC_W-1:0] vec_z = '0;
  logic done;
  logic signed [qvr_pkg::OUT_W-1:0] out_x;
  logic signed [qvr_pkg::OUT_W-1:0] out_y;
  logic signed [qvr_pkg::OUT_W-1:0] out_z;
  logic saturated;

  rot_req_t pending_reqs[$];
  rot_res_t expected_rots[$];
  rot_req_t offered_req;
  int gap_left = 0;
  int burst_left = 0;
  int mismatches = 0;
  longint cycles = 0;

  quaternion_vector_rotate_core #(
    .VEC_WIDTH(VEC_W),
    .QUAT_FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .q_w(q_w),
    .q_x(q_x),
    .q_y(q_y),
    .q_z(q_z),
    .vec_x(vec_x),
    .vec_y(vec_y),
    .vec_z(vec_z),
    .done(done),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // product of two Q1.14 values back at 14 fractional bits, nearest, ties up
  function automatic longint q_round(longint p);
    return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic rot_res_t rotate_vector(rot_req_t r);
    longint w, x, y, z, one;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint m[3][3];
    longint v[3];
    longint acc;
    logic signed [qvr_pkg::OUT_W-1:0] lane[3];
    logic clipped;
    rot_res_t o;
    w = longint'(r.q_w);
    x = longint'(r.q_x);
    y = longint'(r.q_y);
    z = longint'(r.q_z);
    v[0] = longint'(r.vec_x);
    v[1] = longint'(r.vec_y);
    v[2] = longint'(r.vec_z);
    one = longint'(1) <<< FRAC;
    xx = q_round(x * x);
    yy = q_round(y * y);
    zz = q_round(z * z);
    xy = q_round(x * y);
    xz = q_round(x * z);
    yz = q_round(y * z);
    wx = q_round(w * x);
    wy = q_round(w * y);
    wz = q_round(w * z);
    m[0][0] = one - 2 * (yy + zz);
    m[0][1] = 2 * (xy - wz);
    m[0][2] = 2 * (xz + wy);
    m[1][0] = 2 * (xy + wz);
    m[1][1] = one - 2 * (xx + zz);
    m[1][2] = 2 * (yz - wx);
    m[2][0] = 2 * (xz - wy);
    m[2][1] = 2 * (yz + wx);
    m[2][2] = one - 2 * (xx + yy);
    clipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      // earth to body uses the transposed matrix
      for (int j = 0; j < 3; j++)
        acc += (r.action ? m[j][i] : m[i][j]) * v[j];
      acc = q_round(acc);
      if (acc > longint'(qvr_pkg::OUT_MAX)) begin
        acc = longint'(qvr_pkg::OUT_MAX);
        clipped = 1'b1;
      end else if (acc < longint'(qvr_pkg::OUT_MIN)) begin
        acc = longint'(qvr_pkg::OUT_MIN);
        clipped = 1'b1;
      end
      lane[i] = acc[qvr_pkg::OUT_W-1:0];
    end
    o.out_x = lane[0];
    o.out_y = lane[1];
    o.out_z = lane[2];
    o.saturated = clipped;
    return o;
  endfunction

  task automatic add_req(input logic a, input int w, input int x, input int y, input int z,
                         input int vx, input int vy, input int vz);
    rot_req_t r;
    r.action = a;
    r.q_w = w[Q_W-1:0];
    r.q_x = x[Q_W-1:0];
    r.q_y = y[Q_W-1:0];
    r.q_z = z[Q_W-1:0];
    r.vec_x = vx[VEC_W-1:0];
    r.vec_y = vy[VEC_W-1:0];
    r.vec_z = vz[VEC_W-1:0];
    pending_reqs.push_back(r);
  endtask

  function automatic int random_vec_comp();
    if ($urandom_range(0, 9) < 6)
      return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  // mostly unit quaternions with a little deviation, then wider and raw ones
  task automatic add_random_req();
    real c[4];
    real n;
    int q[4];
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      do begin
        n = 0.0;
        for (int k = 0; k < 4; k++) begin
          c[k] = real'($urandom_range(0, 32768)) - 16384.0;
          n += c[k] * c[k];
        end
      end while (n < 1.0e4);
      n = $sqrt(n);
      for (int k = 0; k < 4; k++) begin
        q[k] = int'(c[k] * 16384.0 / n);
        if ($urandom_range(0, 3) == 0)
          q[k] += int'($urandom_range(0, 64)) - 32;
      end
    end else if (kind < 9) begin
      for (int k = 0; k < 4; k++)
        q[k] = int'($urandom_range(0, 32768)) - 16384;
    end else begin
      for (int k = 0; k < 4; k++)
        q[k] = int'($urandom_range(0, 65535)) - 32768;
    end
    add_req($urandom_range(0, 1), q[0], q[1], q[2], q[3],
            random_vec_comp(), random_vec_comp(), random_vec_comp());
  endtask

  // driver: one transaction per accepted start, random gaps with idle-free bursts
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_rots.push_back(rotate_vector(offered_req));
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        offered_req = pending_reqs.pop_front();
        action <= offered_req.action;
        q_w <= offered_req.q_w;
        q_x <= offered_req.q_x;
        q_y <= offered_req.q_y;
        q_z <= offered_req.q_z;
        vec_x <= offered_req.vec_x;
        vec_y <= offered_req.vec_y;
        vec_z <= offered_req.vec_z;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          burst_left = $urandom_range(10, 40);
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, MAX_GAP);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rot_res_t exp_res;
    if (!rst && done) begin
      if (expected_rots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: x=%0d y=%0d z=%0d sat=%0b",
                   out_x, out_y, out_z, saturated);
      end else begin
        exp_res = expected_rots.pop_front();
        if (out_x !== exp_res.out_x || out_y !== exp_res.out_y ||
            out_z !== exp_res.out_z || saturated !== exp_res.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                     exp_res.out_x, exp_res.out_y, exp_res.out_z, exp_res.saturated,
                     out_x, out_y, out_z, saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    // identity, both directions, vector extremes
    add_req(1'b0, 16384, 0, 0, 0, 32767, -32768, 1);
    add_req(1'b1, 16384, 0, 0, 0, 32767, -32768, 1);
    add_req(1'b0, 16384, 0, 0, 0, 0, 0, 0);
    // quarter turn about z
    add_req(1'b0, 11585, 0, 0, 11585, 1000, 2000, 3000);
    add_req(1'b1, 11585, 0, 0, 11585, 1000, 2000, 3000);
    // half turns about each axis, then the negated identity
    add_req(1'b0, 0, 16384, 0, 0, 32767, 32767, 32767);
    add_req(1'b1, 0, 0, 16384, 0, -32768, -32768, -32768);
    add_req(1'b0, 0, 0, 0, 16384, -32768, 32767, -1);
    add_req(1'b1, -16384, 0, 0, 0, 12345, -23456, 7);
    // quaternions at the ends of the range, -32768 taken as -2.0 and 32767 as just under 2.0
    add_req(1'b0, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
    add_req(1'b1, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_req(1'b0, 32767, 32767, 32767, 32767, 32767, -32768, 32767);
    // non-unit quaternions, no normalisation
    add_req(1'b0, 0, 0, 0, 0, 32767, 32767, -32768);
    add_req(1'b1, 8192, 8192, 0, 0, 20000, -20000, 5);
    // saturation on large results
    add_req(1'b0, 16384, 16384, 16384, 16384, -32768, -32768, -32768);
    add_req(1'b1, -16384, 16384, -16384, 16384, 32767, 0, -32768);
    // rounding ties near small values
    add_req(1'b0, 15137, 6270, 0, 0, -1, -1, -1);
    add_req(1'b1, 1, -1, 1, -1, 1, 1, 1);
    add_req(1'b0, 8192, -8192, 8192, -8192, 3, -3, 2);
    for (int n = 0; n < N_RANDOM; n++)
      add_random_req();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() > 0 || start)
      @(posedge clk);
    while (expected_rots.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

### files.f
hdl/qvr_pkg.sv
hdl/qvr_matrix.sv
hdl/qvr_lane.sv
hdl/qvr_merge.sv
hdl/quaternion_vector_rotate_core.sv
tb/sv/testbench.sv
